// ----- src/lpc_pkg.sv -----
`default_nettype none

package lpc_pkg;

  localparam int unsigned SideW  = 8;
  localparam int unsigned CountW = 64;
  localparam int unsigned StatW  = 2;

  typedef enum logic [StatW-1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_INVALID  = 2'd2
  } status_e;

  // one buffer cell: value plus sticky overflow
  typedef struct packed {
    logic              ovf;
    logic [CountW-1:0] val;
  } cell_t;

  localparam int unsigned CellW = CountW + 1;

endpackage

`default_nettype wire

// ----- src/lpc_if.sv -----
`default_nettype none

interface lpc_in_if;
  logic                     valid;
  logic                     ready;
  logic [lpc_pkg::SideW-1:0] rows;
  logic [lpc_pkg::SideW-1:0] cols;

  modport source (output valid, output rows, output cols, input ready);
  modport sink   (input valid, input rows, input cols, output ready);
endinterface

interface lpc_out_if;
  logic                      valid;
  logic                      ready;
  logic [lpc_pkg::CountW-1:0] path_count;
  logic [lpc_pkg::StatW-1:0]  status;

  modport source (output valid, output path_count, output status, input ready);
  modport sink   (input valid, input path_count, input status, output ready);
endinterface

`default_nettype wire

// ----- src/lpc_ram.sv -----
`default_nettype none

module lpc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- src/lpc_sat_add.sv -----
`default_nettype none

module lpc_sat_add (
  input  wire lpc_pkg::cell_t a_i,
  input  wire lpc_pkg::cell_t b_i,
  output      lpc_pkg::cell_t sum_o
);
  import lpc_pkg::*;

  logic [CountW:0] raw;
  logic            ovf;

  assign raw = {1'b0, a_i.val} + {1'b0, b_i.val};
  assign ovf = a_i.ovf | b_i.ovf | raw[CountW];

  always_comb begin
    sum_o.ovf = ovf;
    sum_o.val = ovf ? {CountW{1'b1}} : raw[CountW-1:0];
  end

endmodule

`default_nettype wire

// ----- src/lattice_path_counter.sv -----
`default_nettype none

// Lattice path counter: for a grid of rows x cols points, returns the number
// of monotone (down/right) paths, C(rows+cols-2, rows-1), as a 64-bit count.
// One beat in gives one beat out. The count is built row by row in a
// one-row buffer (a RAM of MAX_SIDE cells, 65 bits each) as wide as the
// shorter side s, using one shared saturating 64-bit adder; the long side l
// sets the number of passes. Each pass primes the RAM read, then does one
// add and write per cell from 1 to s-1. A side of one goes straight to the
// result. A zero side, or a side above MAX_SIDE, also goes straight to the
// result, with count 0 and status 2 (invalid).
// Once any partial sum overflows, the result is all ones with status 1;
// an exact count of 2^64-1 reports status 0. The input is ready only while
// the block is idle; a finished result stays in the output register until
// taken, and the next grid may be accepted meanwhile.
module lattice_path_counter #(
  parameter int unsigned MAX_SIDE = 255
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  lpc_in_if.sink    in_i,
  lpc_out_if.source out_o
);
  import lpc_pkg::*;

  localparam int unsigned AddrW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam logic [12:0] MaxSide = 13'(MAX_SIDE);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ROW,
    S_CELL,
    S_FINISH
  } state_e;

  state_e               state_q;
  logic [SideW-1:0]     short_q, long_q;   // s and l
  logic [SideW-1:0]     row_q;             // current pass, 1..l-1
  logic [SideW-1:0]     col_q;             // current cell, 1..s-1
  cell_t                prev_q;            // cell c-1 of the current pass
  logic                 invalid_q;
  logic                 out_valid_q;
  logic [CountW-1:0]    out_count_q;
  status_e              out_status_q;

  // input decode
  logic             side_bad;
  logic [SideW-1:0] in_short, in_long;

  assign side_bad = (in_i.rows == '0) || (in_i.cols == '0) ||
                    ({5'b0, in_i.rows} > MaxSide) || ({5'b0, in_i.cols} > MaxSide);
  assign in_short = (in_i.rows < in_i.cols) ? in_i.rows : in_i.cols;
  assign in_long  = (in_i.rows < in_i.cols) ? in_i.cols : in_i.rows;

  logic in_fire;
  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;

  // buffer RAM and shared adder
  logic             ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  cell_t            ram_rdata, old_cell, sum_cell;
  logic [CellW-1:0] ram_rdata_raw;

  lpc_ram #(
    .Width (CellW),
    .Depth (MAX_SIDE)
  ) u_row_buf (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (sum_cell),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata_raw)
  );

  assign ram_rdata = cell_t'(ram_rdata_raw);

  // first pass: every buffer cell starts at one, so skip the RAM
  always_comb begin
    if (row_q == SideW'(1)) begin
      old_cell.ovf = 1'b0;
      old_cell.val = CountW'(1);
    end else begin
      old_cell = ram_rdata;
    end
  end

  lpc_sat_add u_add (
    .a_i   (old_cell),
    .b_i   (prev_q),
    .sum_o (sum_cell)
  );

  logic row_end, last_row;
  assign row_end  = (col_q == short_q - SideW'(1));
  assign last_row = (row_q == long_q - SideW'(1));

  assign ram_we    = (state_q == S_CELL);
  assign ram_waddr = AddrW'(col_q);
  assign ram_re    = (state_q == S_ROW) || ((state_q == S_CELL) && !row_end);
  assign ram_raddr = (state_q == S_ROW) ? AddrW'(1) : AddrW'(col_q + SideW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      out_valid_q  <= 1'b0;
      row_q        <= '0;
      col_q        <= '0;
      short_q      <= '0;
      long_q       <= '0;
      prev_q       <= '0;
      invalid_q    <= 1'b0;
      out_count_q  <= '0;
      out_status_q <= ST_OK;
    end else begin
      // a new result in S_FINISH overrides the drain of the old one
      if (out_valid_q && out_o.ready && (state_q != S_FINISH)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            short_q      <= in_short;
            long_q       <= in_long;
            row_q        <= SideW'(1);
            col_q        <= '0;
            invalid_q    <= side_bad;
            prev_q.ovf   <= 1'b0;
            prev_q.val   <= side_bad ? '0 : CountW'(1);
            if (side_bad || in_short == SideW'(1)) begin
              state_q <= S_FINISH;
            end else begin
              state_q <= S_ROW;
            end
          end
        end
        S_ROW: begin
          // prime the read of cell 1; cell 0 is always one
          col_q      <= SideW'(1);
          prev_q.ovf <= 1'b0;
          prev_q.val <= CountW'(1);
          state_q    <= S_CELL;
        end
        S_CELL: begin
          prev_q <= sum_cell;
          if (row_end) begin
            if (last_row) begin
              state_q <= S_FINISH;
            end else begin
              row_q   <= row_q + SideW'(1);
              state_q <= S_ROW;
            end
          end else begin
            col_q <= col_q + SideW'(1);
          end
        end
        S_FINISH: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q  <= 1'b1;
            out_count_q  <= prev_q.val;
            out_status_q <= invalid_q  ? ST_INVALID  :
                            prev_q.ovf ? ST_OVERFLOW : ST_OK;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.path_count = out_count_q;
  assign out_o.status     = out_status_q;

endmodule

`default_nettype wire

// ----- verif/lpc_path_checker.sv -----
`default_nettype none

// Watches the grid and count channels, predicts each count and compares.
module lpc_path_checker #(
  parameter int unsigned MAX_SIDE = 255
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  lpc_in_if           grid_i,
  lpc_out_if          count_i,
  output logic [31:0] fail_count_o,
  output logic [31:0] backlog_o
);
  import lpc_pkg::*;

  typedef struct packed {
    logic [SideW-1:0]  rows;
    logic [SideW-1:0]  cols;
    logic [CountW-1:0] count;
    status_e           status;
  } grid_result_t;

  grid_result_t pending_counts[$];
  grid_result_t want;
  int unsigned  errors = 0;

  assign fail_count_o = errors;

  // one-row DP, short side wide, sticky overflow per cell
  function automatic grid_result_t count_paths(input logic [SideW-1:0] m,
                                               input logic [SideW-1:0] n);
    cell_t         path_row [MAX_SIDE];
    grid_result_t  res;
    int unsigned   short_side;
    int unsigned   long_side;
    logic [CountW:0] sum;
    res.rows = m;
    res.cols = n;
    if (m == 0 || n == 0 || m > MAX_SIDE || n > MAX_SIDE) begin
      res.count  = '0;
      res.status = ST_INVALID;
      return res;
    end
    short_side = (m < n) ? 32'(m) : 32'(n);
    long_side  = (m < n) ? 32'(n) : 32'(m);
    for (int c = 0; c < short_side; c++) begin
      path_row[c].ovf = 1'b0;
      path_row[c].val = CountW'(1);
    end
    for (int r = 1; r < long_side; r++) begin
      for (int c = 1; c < short_side; c++) begin
        sum = {1'b0, path_row[c].val} + {1'b0, path_row[c-1].val};
        if (path_row[c].ovf || path_row[c-1].ovf || sum[CountW]) begin
          path_row[c].ovf = 1'b1;
          path_row[c].val = '1;
        end else begin
          path_row[c].ovf = 1'b0;
          path_row[c].val = sum[CountW-1:0];
        end
      end
    end
    if (path_row[short_side-1].ovf) begin
      res.count  = '1;
      res.status = ST_OVERFLOW;
    end else begin
      res.count  = path_row[short_side-1].val;
      res.status = ST_OK;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_counts.delete();
      backlog_o <= '0;
    end else begin
      if (grid_i.valid && grid_i.ready)
        pending_counts.push_back(count_paths(grid_i.rows, grid_i.cols));
      if (count_i.valid && count_i.ready) begin
        if (pending_counts.size() == 0) begin
          report_mismatch($sformatf("count beat %0d with no grid pending",
                                    count_i.path_count));
        end else begin
          want = pending_counts.pop_front();
          if (count_i.path_count !== want.count)
            report_mismatch($sformatf("%0dx%0d count got %0d exp %0d",
                                      want.rows, want.cols,
                                      count_i.path_count, want.count));
          if (count_i.status !== want.status)
            report_mismatch($sformatf("%0dx%0d status got %0d exp %0d",
                                      want.rows, want.cols,
                                      count_i.status, want.status));
        end
      end
      backlog_o <= 32'(pending_counts.size());
    end
  end

endmodule

`default_nettype wire

// ----- verif/lattice_path_counter_test.sv -----
`default_nettype none

// Top of the lattice path counter bench. It only makes stimulus and gives
// the verdict; prediction and comparison live in lpc_path_checker.
module lattice_path_counter_test;
  import lpc_pkg::*;

  localparam int unsigned MAX_SIDE = 255;
  localparam int unsigned NumRandom = 80;
  localparam int unsigned NumDirected = 20;

  // directed grids: zero sides, unit sides, thin strips, the last grid that
  // fits in 64 bits (34x35) and the first that saturates (35x35), and the
  // full 255x255 grid, which is also the slowest one the block can take
  localparam logic [SideW-1:0] DirRows [NumDirected] = '{
    8'd1, 8'd0, 8'd0, 8'd255, 8'd0, 8'd1, 8'd255, 8'd1, 8'd2, 8'd2,
    8'd2, 8'd255, 8'd3, 8'd7, 8'd34, 8'd35, 8'd35, 8'd17, 8'd130, 8'd255
  };
  localparam logic [SideW-1:0] DirCols [NumDirected] = '{
    8'd1, 8'd0, 8'd255, 8'd0, 8'd1, 8'd255, 8'd1, 8'd2, 8'd1, 8'd2,
    8'd255, 8'd2, 8'd7, 8'd3, 8'd35, 8'd34, 8'd35, 8'd17, 8'd128, 8'd255
  };

  // receiver stall styles, each held for a random stretch
  typedef enum logic [1:0] {
    SINK_OPEN,    // always ready, no stalls at all
    SINK_COIN,    // ready half the time
    SINK_SPARSE,  // ready one cycle in four on average
    SINK_TOGGLE   // ready every other cycle
  } sink_mode_e;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic [31:0] fail_count;
  logic [31:0] grid_backlog;

  sink_mode_e  sink_mode = SINK_OPEN;
  int unsigned sink_left = 0;
  int unsigned burst_left = 0;

  lpc_in_if  grid_if ();
  lpc_out_if count_if ();

  lattice_path_counter #(
    .MAX_SIDE(MAX_SIDE)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (grid_if),
    .out_o (count_if)
  );

  lpc_path_checker #(
    .MAX_SIDE(MAX_SIDE)
  ) path_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .grid_i      (grid_if),
    .count_i     (count_if),
    .fail_count_o(fail_count),
    .backlog_o   (grid_backlog)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Hard stop. The slow grids are the 255x255-class ones (one directed,
  // at most five random); the rest are small.
  initial begin
    #8_000_000;
    $display("[lattice_path_counter] ERROR");
    $finish;
  end

  // Receiver: ready changes on the falling edge, following a stall style
  // that is redrawn after a random stretch.
  always @(negedge clk_i) begin
    if (sink_left == 0) begin
      sink_mode = sink_mode_e'($urandom_range(0, 3));
      sink_left = $urandom_range(8, 64);
    end else begin
      sink_left--;
    end
    case (sink_mode)
      SINK_OPEN:   count_if.ready = 1'b1;
      SINK_COIN:   count_if.ready = 1'($urandom_range(0, 1));
      SINK_SPARSE: count_if.ready = ($urandom_range(0, 3) == 0);
      default:     count_if.ready = ~count_if.ready;
    endcase
  end

  // One grid beat. Called right after a falling edge; returns right after
  // the falling edge that follows acceptance. valid stays high across a
  // burst, so back-to-back beats never drop it. Between bursts the side
  // fields carry junk while valid is low.
  task automatic send_grid(input logic [SideW-1:0] rows,
                           input logic [SideW-1:0] cols);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        grid_if.valid = 1'b0;
        repeat (gap) begin
          grid_if.rows = SideW'($urandom);
          grid_if.cols = SideW'($urandom);
          @(negedge clk_i);
        end
      end
      burst_left = $urandom_range(1, 8);
    end
    burst_left--;
    grid_if.valid = 1'b1;
    grid_if.rows  = rows;
    grid_if.cols  = cols;
    // ready is sampled at the rising edge, before that edge's updates land
    do @(posedge clk_i); while (!grid_if.ready);
    @(negedge clk_i);
  endtask

  initial begin
    logic [SideW-1:0] side_a;
    logic [SideW-1:0] side_b;
    int unsigned      pick;

    grid_if.valid  = 1'b0;
    grid_if.rows   = '0;
    grid_if.cols   = '0;
    count_if.ready = 1'b0;

    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < NumDirected; i++)
      send_grid(DirRows[i], DirCols[i]);

    // Random grids. Cost grows with short*long, so most sides stay at
    // or below 48 (which still crosses the 64-bit overflow edge near 35);
    // only every 16th grid may have both sides in the full side range.
    for (int i = 0; i < NumRandom; i++) begin
      pick = $urandom_range(0, 15);
      if (i % 16 == 15) begin
        side_a = SideW'($urandom_range(0, 255));
        side_b = SideW'($urandom_range(0, 255));
      end else if (pick == 0) begin
        // zero side: invalid, the other side anything
        side_a = '0;
        side_b = SideW'($urandom_range(0, 255));
      end else if (pick == 1) begin
        // unit side: count is 1 unless the other side is zero
        side_a = SideW'(1);
        side_b = SideW'($urandom_range(0, 255));
      end else if (pick == 2) begin
        // narrow strip, other side anywhere from 1 to 255
        side_a = SideW'($urandom_range(2, 3));
        side_b = SideW'($urandom_range(1, 255));
      end else begin
        side_a = SideW'($urandom_range(1, 48));
        side_b = SideW'($urandom_range(1, 48));
      end
      if ($urandom_range(0, 1))
        send_grid(side_a, side_b);
      else
        send_grid(side_b, side_a);
    end
    grid_if.valid = 1'b0;

    // drain: every grid gives exactly one count
    while (grid_backlog != 0) @(posedge clk_i);
    // wait on to catch any stray count beat
    repeat (64) @(posedge clk_i);

    if (fail_count == 0)
      $display("[lattice_path_counter] OK");
    else
      $display("[lattice_path_counter] ERROR");
    $finish;
  end

endmodule

`default_nettype wire
